// ----- rtl/compressor_start_stop_sequencer_defines.svh -----
// assertion macros for the compressor start/stop sequencer
`ifndef COMPRESSOR_START_STOP_SEQUENCER_DEFINES_SVH
`define COMPRESSOR_START_STOP_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define CSS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("css assertion failed");
// next-cycle implication, disabled while in reset
`define CSS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("css assertion failed");
`else
`define CSS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CSS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/css_pkg.sv -----
// shared types and constants for the compressor start/stop sequencer
package css_pkg;

    localparam int TIMER_WIDTH_DEF = 20;
    localparam int CFG_AW          = 5;
    localparam int IN_TDATA_W      = 80;
    localparam int OUT_TDATA_W     = 96;

    localparam logic [2:0] REG_NOMINAL_SPEED   = 3'd0;
    localparam logic [2:0] REG_MIN_RUN_SPEED   = 3'd1;
    localparam logic [2:0] REG_STOPPED_SPEED   = 3'd2;
    localparam logic [2:0] REG_WAIT_TICKS      = 3'd3;
    localparam logic [2:0] REG_START_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_FAULT_HOLD      = 3'd5;
    localparam logic [2:0] REG_SEND_DIVIDER    = 3'd6;

    localparam logic [15:0] RST_NOMINAL_SPEED  = 16'd6000;
    localparam logic [15:0] RST_MIN_RUN_SPEED  = 16'd1000;
    localparam logic [15:0] RST_STOPPED_SPEED  = 16'd3500;
    localparam logic [19:0] RST_WAIT_TICKS     = 20'd300;
    localparam logic [19:0] RST_START_TIMEOUT  = 20'd60000;
    localparam logic [19:0] RST_FAULT_HOLD     = 20'd5000;
    localparam logic [7:0]  RST_SEND_DIVIDER   = 8'd10;

    localparam logic [2:0] ST_SLEEP = 3'd0;
    localparam logic [2:0] ST_WAIT  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_STOP  = 3'd4;
    localparam logic [2:0] ST_FAULT = 3'd5;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [10:0]       FEEDBACK_ID = 11'h248;
    localparam logic signed [8:0] TEMP_OFFSET = 9'sd40;

    typedef struct packed {
        logic [15:0] nominal_speed;
        logic [15:0] min_running_speed;
        logic [15:0] stopped_speed;
        logic [19:0] wait_ticks;
        logic [19:0] start_timeout_ticks;
        logic [19:0] fault_hold_ticks;
        logic [7:0]  send_divider;
    } css_cfg_t;

    typedef struct packed {
        logic [7:0]        power_tenths;
        logic [9:0]        supply_volts;
        logic [7:0]        current_fifths;
        logic signed [8:0] temperature_c;
        logic [7:0]        error_bits;
        logic [7:0]        status_code;
        logic [15:0]       measured_speed;
        logic              frame_due;
        logic              start_failed;
        logic [15:0]       speed_reference;
        logic              enable_out;
        logic [2:0]        seq_state;
    } css_result_t;

endpackage

// ----- rtl/css_regfile.sv -----
// configuration register file with apb-style access
module css_regfile
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [css_pkg::CFG_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output css_pkg::css_cfg_t              cfg
);

    css_pkg::css_cfg_t cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nominal_speed       <= css_pkg::RST_NOMINAL_SPEED;
            cfg_reg.min_running_speed   <= css_pkg::RST_MIN_RUN_SPEED;
            cfg_reg.stopped_speed       <= css_pkg::RST_STOPPED_SPEED;
            cfg_reg.wait_ticks          <= css_pkg::RST_WAIT_TICKS;
            cfg_reg.start_timeout_ticks <= css_pkg::RST_START_TIMEOUT;
            cfg_reg.fault_hold_ticks    <= css_pkg::RST_FAULT_HOLD;
            cfg_reg.send_divider        <= css_pkg::RST_SEND_DIVIDER;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                css_pkg::REG_NOMINAL_SPEED: cfg_reg.nominal_speed       <= pwdata[15:0];
                css_pkg::REG_MIN_RUN_SPEED: cfg_reg.min_running_speed   <= pwdata[15:0];
                css_pkg::REG_STOPPED_SPEED: cfg_reg.stopped_speed       <= pwdata[15:0];
                css_pkg::REG_WAIT_TICKS:    cfg_reg.wait_ticks          <= pwdata[19:0];
                css_pkg::REG_START_TIMEOUT: cfg_reg.start_timeout_ticks <= pwdata[19:0];
                css_pkg::REG_FAULT_HOLD:    cfg_reg.fault_hold_ticks    <= pwdata[19:0];
                css_pkg::REG_SEND_DIVIDER:  cfg_reg.send_divider        <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            css_pkg::REG_NOMINAL_SPEED: prdata = {16'd0, cfg_reg.nominal_speed};
            css_pkg::REG_MIN_RUN_SPEED: prdata = {16'd0, cfg_reg.min_running_speed};
            css_pkg::REG_STOPPED_SPEED: prdata = {16'd0, cfg_reg.stopped_speed};
            css_pkg::REG_WAIT_TICKS:    prdata = {12'd0, cfg_reg.wait_ticks};
            css_pkg::REG_START_TIMEOUT: prdata = {12'd0, cfg_reg.start_timeout_ticks};
            css_pkg::REG_FAULT_HOLD:    prdata = {12'd0, cfg_reg.fault_hold_ticks};
            css_pkg::REG_SEND_DIVIDER:  prdata = {24'd0, cfg_reg.send_divider};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/css_seq.sv -----
// sequencer state, feedback decode and frame divider, one item per step
module css_seq
#(
    parameter int TIMER_WIDTH = css_pkg::TIMER_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  css_pkg::css_cfg_t     cfg,
    input  logic                  cmd,
    input  logic                  enable_request,
    input  logic [10:0]           frame_id,
    input  logic [31:0]           frame_bytes_low,
    input  logic [31:0]           frame_bytes_high,
    output css_pkg::css_result_t  res
);

    logic [2:0]             state_reg,     state_next;
    logic [TIMER_WIDTH-1:0] countdown_reg, countdown_next;
    logic                   flag_reg,      flag_next;
    logic [7:0]             send_cnt_reg,  send_cnt_next;
    logic                   ref_en_reg,    ref_en_next;
    logic [15:0]            ref_speed_reg, ref_speed_next;
    logic [15:0]            speed_fb_reg,  speed_fb_next;
    logic [7:0]             status_fb_reg, status_fb_next;
    logic [7:0]             error_fb_reg,  error_fb_next;
    logic signed [8:0]      temp_fb_reg,   temp_fb_next;
    logic [7:0]             current_fb_reg, current_fb_next;
    logic [9:0]             voltage_fb_reg, voltage_fb_next;
    logic [7:0]             power_fb_reg,  power_fb_next;

    logic [TIMER_WIDTH-1:0] cd_dec;
    logic                   cd_expired;
    logic [8:0]             cnt_sum;
    logic                   due;

    // saturate a register load to the countdown range
    function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [19:0] ticks);
        logic [31:0] wide;
        begin
            wide = 32'(ticks);
            if ((wide >> TIMER_WIDTH) != 32'd0)
                sat_load = '1;
            else
                sat_load = wide[TIMER_WIDTH-1:0];
        end
    endfunction

    assign cd_dec     = (countdown_reg != '0) ? countdown_reg - 1'b1 : '0;
    assign cd_expired = (cd_dec == '0);
    assign cnt_sum    = {1'b0, send_cnt_reg} + 9'd1;

    always_comb
    begin
        state_next      = state_reg;
        countdown_next  = countdown_reg;
        flag_next       = flag_reg;
        send_cnt_next   = send_cnt_reg;
        ref_en_next     = ref_en_reg;
        ref_speed_next  = ref_speed_reg;
        speed_fb_next   = speed_fb_reg;
        status_fb_next  = status_fb_reg;
        error_fb_next   = error_fb_reg;
        temp_fb_next    = temp_fb_reg;
        current_fb_next = current_fb_reg;
        voltage_fb_next = voltage_fb_reg;
        power_fb_next   = power_fb_reg;
        due             = 1'b0;

        if (cmd == css_pkg::CMD_TICK)
        begin
            case (state_reg)
                css_pkg::ST_SLEEP:
                begin
                    ref_en_next    = 1'b0;
                    ref_speed_next = 16'd0;
                    if (enable_request)
                    begin
                        state_next     = css_pkg::ST_WAIT;
                        countdown_next = sat_load(cfg.wait_ticks);
                    end
                end
                css_pkg::ST_WAIT:
                begin
                    ref_en_next    = 1'b1;
                    ref_speed_next = 16'd0;
                    countdown_next = cd_dec;
                    if (cd_expired)
                    begin
                        state_next     = css_pkg::ST_START;
                        countdown_next = sat_load(cfg.start_timeout_ticks);
                    end
                end
                css_pkg::ST_START:
                begin
                    ref_en_next    = 1'b1;
                    ref_speed_next = cfg.nominal_speed;
                    countdown_next = cd_dec;
                    if (speed_fb_reg > cfg.min_running_speed)
                    begin
                        state_next = css_pkg::ST_RUN;
                        flag_next  = 1'b0;
                    end
                    // timeout wins over success
                    if (cd_expired)
                    begin
                        state_next     = css_pkg::ST_FAULT;
                        flag_next      = 1'b1;
                        countdown_next = sat_load(cfg.fault_hold_ticks);
                    end
                end
                css_pkg::ST_RUN:
                begin
                    ref_en_next    = 1'b1;
                    ref_speed_next = cfg.nominal_speed;
                    if (!enable_request)
                        state_next = css_pkg::ST_STOP;
                    if (error_fb_reg != 8'd0)
                        state_next = css_pkg::ST_FAULT;
                end
                css_pkg::ST_STOP:
                begin
                    ref_en_next    = 1'b1;
                    ref_speed_next = 16'd0;
                    if (speed_fb_reg < cfg.stopped_speed)
                        state_next = css_pkg::ST_SLEEP;
                end
                css_pkg::ST_FAULT:
                begin
                    ref_en_next    = 1'b0;
                    ref_speed_next = 16'd0;
                    // hold timer only runs after a start failure
                    if (flag_reg)
                        countdown_next = cd_dec;
                    if (!flag_reg || cd_expired)
                    begin
                        flag_next = 1'b0;
                        if (error_fb_reg == 8'd0)
                            state_next = css_pkg::ST_SLEEP;
                    end
                end
                default:
                begin
                    ref_en_next    = 1'b0;
                    ref_speed_next = 16'd0;
                    state_next     = css_pkg::ST_SLEEP;
                end
            endcase

            if (cnt_sum >= {1'b0, cfg.send_divider})
            begin
                send_cnt_next = 8'd0;
                due           = 1'b1;
            end
            else
            begin
                send_cnt_next = cnt_sum[7:0];
            end
        end
        else if (frame_id == css_pkg::FEEDBACK_ID)
        begin
            speed_fb_next   = frame_bytes_low[15:0];
            power_fb_next   = frame_bytes_low[23:16];
            status_fb_next  = frame_bytes_low[31:24];
            error_fb_next   = frame_bytes_high[7:0];
            temp_fb_next    = $signed({1'b0, frame_bytes_high[15:8]}) - css_pkg::TEMP_OFFSET;
            current_fb_next = frame_bytes_high[23:16];
            voltage_fb_next = {frame_bytes_high[31:24], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= css_pkg::ST_SLEEP;
            countdown_reg  <= '0;
            flag_reg       <= 1'b0;
            send_cnt_reg   <= 8'd0;
            ref_en_reg     <= 1'b0;
            ref_speed_reg  <= 16'd0;
            speed_fb_reg   <= 16'd0;
            status_fb_reg  <= 8'd0;
            error_fb_reg   <= 8'd0;
            temp_fb_reg    <= 9'sd0;
            current_fb_reg <= 8'd0;
            voltage_fb_reg <= 10'd0;
            power_fb_reg   <= 8'd0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            countdown_reg  <= countdown_next;
            flag_reg       <= flag_next;
            send_cnt_reg   <= send_cnt_next;
            ref_en_reg     <= ref_en_next;
            ref_speed_reg  <= ref_speed_next;
            speed_fb_reg   <= speed_fb_next;
            status_fb_reg  <= status_fb_next;
            error_fb_reg   <= error_fb_next;
            temp_fb_reg    <= temp_fb_next;
            current_fb_reg <= current_fb_next;
            voltage_fb_reg <= voltage_fb_next;
            power_fb_reg   <= power_fb_next;
        end
    end

    assign res.seq_state       = state_next;
    assign res.enable_out      = ref_en_next;
    assign res.speed_reference = ref_speed_next;
    assign res.start_failed    = flag_next;
    assign res.frame_due       = due;
    assign res.measured_speed  = speed_fb_next;
    assign res.status_code     = status_fb_next;
    assign res.error_bits      = error_fb_next;
    assign res.temperature_c   = temp_fb_next;
    assign res.current_fifths  = current_fb_next;
    assign res.supply_volts    = voltage_fb_next;
    assign res.power_tenths    = power_fb_next;

endmodule

// ----- rtl/compressor_start_stop_sequencer.sv -----
// top level of the compressor start/stop sequencer
//
// input stream: one item per tick or per received frame. s_axis_tuser is the
// kind (0 tick, 1 feedback frame); s_axis_tdata carries the enable request,
// the frame identifier and the eight frame bytes. only identifier 0x248 is
// decoded; other frames leave everything unchanged.
// output stream: one result item per input item with the sequencer state,
// the enable and speed references, the start error flag, the frame-due flag
// and the kept feedback values.
// a result passes one input register, then the sequencer step into the output
// register, which drives m_axis_tvalid. throughput is one item per cycle while
// the receiver does not stall; the sequencer state updates once per item.
// when the receiver stalls, the result waits in the output register and one
// more item can be held in the input register before s_axis_tready drops.
// reset puts the sequencer in sleep with timers, divider and feedback cleared
// and the configuration registers at their defaults. the apb port writes
// registers at byte address 4*index and should only be written while idle.
module compressor_start_stop_sequencer
#(
    parameter int TIMER_WIDTH = css_pkg::TIMER_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] enable_request, [11:1] frame_id, [43:12] frame_bytes_low,
    // [75:44] frame_bytes_high, [79:76] zero
    input  logic [css_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] cmd
    input  logic                             s_axis_tuser,
    // stream out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] seq_state, [3] enable_out, [19:4] speed_reference,
    // [20] start_failed, [21] frame_due, [37:22] measured_speed,
    // [45:38] status_code, [53:46] error_bits, [62:54] temperature_c,
    // [70:63] current_fifths, [80:71] supply_volts, [88:81] power_tenths,
    // [95:89] zero
    output logic [css_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [css_pkg::CFG_AW-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

`include "compressor_start_stop_sequencer_defines.svh"

    css_pkg::css_cfg_t                cfg;
    css_pkg::css_result_t             res;

    logic                             in_valid_reg,  in_valid_next;
    logic [css_pkg::IN_TDATA_W-1:0]   in_tdata_reg;
    logic                             in_tuser_reg;
    logic                             out_valid_reg, out_valid_next;
    css_pkg::css_result_t             out_res_reg;
    logic                             s_accept;
    logic                             advance;

    assign pready        = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    css_regfile u_regfile
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    css_seq #(.TIMER_WIDTH(TIMER_WIDTH)) u_seq
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .cfg              (cfg),
        .cmd              (in_tuser_reg),
        .enable_request   (in_tdata_reg[0]),
        .frame_id         (in_tdata_reg[11:1]),
        .frame_bytes_low  (in_tdata_reg[43:12]),
        .frame_bytes_high (in_tdata_reg[75:44]),
        .res              (res)
    );

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_tdata_reg <= s_axis_tdata;
            in_tuser_reg <= s_axis_tuser;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tdata = {
        7'd0,
        out_res_reg.power_tenths,
        out_res_reg.supply_volts,
        out_res_reg.current_fifths,
        out_res_reg.temperature_c,
        out_res_reg.error_bits,
        out_res_reg.status_code,
        out_res_reg.measured_speed,
        out_res_reg.frame_due,
        out_res_reg.start_failed,
        out_res_reg.speed_reference,
        out_res_reg.enable_out,
        out_res_reg.seq_state
    };

    // input side only stalls with an item parked in the input register
    `CSS_ASSERT_IMP(a_tready_low_only_when_full, clk, rst_n,
        !s_axis_tready, in_valid_reg)
    // an item leaving the input register always lands in the output register
    `CSS_ASSERT_NXT(a_advance_fills_output, clk, rst_n,
        advance, out_valid_reg)
    // the start error flag is only ever seen in fault
    `CSS_ASSERT_IMP(a_flag_only_in_fault, clk, rst_n,
        out_valid_reg && out_res_reg.start_failed,
        out_res_reg.seq_state == css_pkg::ST_FAULT)
    // a nonzero speed reference always comes with enable
    `CSS_ASSERT_IMP(a_speed_needs_enable, clk, rst_n,
        out_valid_reg && (out_res_reg.speed_reference != 16'd0),
        out_res_reg.enable_out)

endmodule
